FILE: sv/scr_pkg.sv
`default_nettype none

package scr_pkg;

  localparam int unsigned PktLen = 7;
  localparam int unsigned PosW   = $clog2(PktLen + 1);

  typedef logic [7:0]      byte_t;
  typedef logic [PosW-1:0] pos_t;

  typedef enum logic {
    ReqSpi  = 1'b0,
    ReqTick = 1'b1
  } req_type_e;

  typedef enum logic {
    RegServoMin = 1'b0,
    RegServoMax = 1'b1
  } reg_idx_e;

  localparam byte_t CmdLampOn    = 8'h10;
  localparam byte_t CmdLampOff   = 8'h11;
  localparam byte_t CmdVentOpen  = 8'h20;
  localparam byte_t CmdVentClose = 8'h21;
  localparam byte_t CmdDoorQuery = 8'h30;
  localparam byte_t CmdStateReq  = 8'h40;
  localparam byte_t CmdLightQry  = 8'h41;
  localparam byte_t CmdDummy     = 8'hFF;

  localparam byte_t RplAck     = 8'h4F;
  localparam byte_t RplErr     = 8'hEE;
  localparam byte_t RplZero    = 8'h00;
  localparam byte_t PktTrailer = 8'hAA;

  localparam logic [14:0] ServoMinReset = 15'd900;
  localparam logic [14:0] ServoMaxReset = 15'd2450;

  localparam pos_t PosLast = pos_t'(PktLen - 1);
  localparam pos_t PosEnd  = pos_t'(PktLen);

  // Snapshot taken on a state request; the packet bytes derive from it.
  typedef struct packed {
    logic [15:0] ts;
    byte_t       light;
    logic [1:0]  door;
    logic        lamp;
  } snap_t;

  // Door code from the two active-low switch pins.
  function automatic logic [1:0] door_code(logic close_lvl, logic open_lvl);
    logic closed_on;
    logic open_on;
    logic [1:0] code;
    closed_on = !close_lvl;
    open_on   = !open_lvl;
    case ({closed_on, open_on})
      2'b10:   code = 2'd1;
      2'b01:   code = 2'd0;
      2'b00:   code = 2'd2;
      default: code = 2'd3;
    endcase
    return code;
  endfunction

  function automatic byte_t pkt_byte(snap_t s, pos_t idx);
    byte_t chk;
    byte_t b;
    chk = s.ts[15:8] ^ s.ts[7:0] ^ s.light ^ {6'b0, s.door} ^ {7'b0, s.lamp};
    case (idx)
      3'd0:    b = s.ts[15:8];
      3'd1:    b = s.ts[7:0];
      3'd2:    b = s.light;
      3'd3:    b = {6'b0, s.door};
      3'd4:    b = {7'b0, s.lamp};
      3'd5:    b = chk;
      default: b = PktTrailer;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: sv/scr_req_if.sv
`default_nettype none

interface scr_req_if;
  import scr_pkg::*;

  logic  valid;
  logic  ready;
  logic  req_type;
  byte_t spi_byte;
  byte_t light_byte;
  logic  close_switch_level;
  logic  open_switch_level;

  modport source (
    output valid, req_type, spi_byte, light_byte, close_switch_level, open_switch_level,
    input  ready
  );

  modport sink (
    input  valid, req_type, spi_byte, light_byte, close_switch_level, open_switch_level,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/scr_rsp_if.sv
`default_nettype none

interface scr_rsp_if;
  import scr_pkg::*;

  logic        valid;
  logic        ready;
  byte_t       reply_byte;
  logic        lamp_on;
  logic [15:0] servo_ticks;

  modport source (
    output valid, reply_byte, lamp_on, servo_ticks,
    input  ready
  );

  modport sink (
    input  valid, reply_byte, lamp_on, servo_ticks,
    output ready
  );
endinterface

`default_nettype wire

FILE: sv/scr_ram.sv
`default_nettype none

module scr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 7,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic                   clk_i,
  input  wire logic                   we_i,
  input  wire logic [AddrW-1:0]       waddr_i,
  input  wire logic [Width-1:0]       wdata_i,
  input  wire logic                   re_i,
  input  wire logic [AddrW-1:0]       raddr_i,
  output logic      [Width-1:0]       rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

`default_nettype wire

FILE: sv/spi_command_responder.sv
`default_nettype none

// SPI command responder. Each transfer on req_i is either a received SPI
// byte or a millisecond tick. A tick advances the 16-bit wrapping timestamp
// and yields no transfer on rsp_o; an SPI byte yields exactly one reply
// transfer, in order, carrying the reply byte plus the lamp and servo compare
// state after that byte. The block takes one transfer per clock; a reply is
// presented the cycle after its byte is taken and waits in the output stage
// while rsp_o stalls, during which req_i is held off. A state request (0x40)
// snapshots timestamp, light, door and lamp; the next six bytes stream the
// rest of the seven-byte packet out of the packet RAM and the seventh gets
// zero. The RAM is filled one byte per cycle after the request; bytes not yet
// written are forwarded from the snapshot. The user must write the servo pulse
// registers through cfg_we_i/cfg_idx_i/cfg_wdata_i only while the block is
// idle; the block itself does not enforce this.

module spi_command_responder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [14:0] cfg_wdata_i,
  scr_req_if.sink          req_i,
  scr_rsp_if.source        rsp_o
);
  import scr_pkg::*;

  // Configuration
  logic [14:0] servo_min_q, servo_max_q;

  // Architectural state
  logic [15:0] ts_q, ts_d;
  logic        lamp_q, lamp_d;
  logic [15:0] servo_q, servo_d;
  logic        strm_q, strm_d;
  pos_t        pos_q, pos_d;

  // Packet fill sweep
  snap_t snap_q, snap_new;
  logic  snap_load;
  logic  sweep_q;
  pos_t  wr_ptr_q;

  // Output stage
  logic        s1_valid_q;
  byte_t       reply_q;
  logic        use_ram_q;
  logic        lamp_out_q;
  logic [15:0] servo_out_q;

  logic  in_ready, req_fire, is_spi, is_tick;
  byte_t reply_new;
  logic  use_ram_new;
  logic  rd_en;
  pos_t  pos_inc;
  byte_t ram_rdata;

  assign in_ready    = !s1_valid_q || rsp_o.ready;
  assign req_i.ready = in_ready;
  assign req_fire    = req_i.valid && in_ready;
  assign is_spi      = req_fire && (req_i.req_type == ReqSpi);
  assign is_tick     = req_fire && (req_i.req_type == ReqTick);
  assign pos_inc     = pos_q + pos_t'(1);

  always_comb begin
    snap_new.ts    = ts_q;
    snap_new.light = req_i.light_byte;
    snap_new.door  = door_code(req_i.close_switch_level, req_i.open_switch_level);
    snap_new.lamp  = lamp_q;
  end

  always_comb begin
    ts_d        = ts_q;
    lamp_d      = lamp_q;
    servo_d     = servo_q;
    strm_d      = strm_q;
    pos_d       = pos_q;
    reply_new   = RplErr;
    use_ram_new = 1'b0;
    rd_en       = 1'b0;
    snap_load   = 1'b0;

    if (is_tick) begin
      ts_d = ts_q + 16'd1;
    end

    if (is_spi) begin
      if (strm_q) begin
        // Ignore the received byte; advance through the packet.
        if (pos_inc == PosEnd) begin
          strm_d    = 1'b0;
          pos_d     = '0;
          reply_new = RplZero;
        end else begin
          pos_d = pos_inc;
          if (sweep_q && (pos_inc >= wr_ptr_q)) begin
            // Not in the RAM yet: forward from the snapshot.
            reply_new = pkt_byte(snap_q, pos_inc);
          end else begin
            use_ram_new = 1'b1;
            rd_en       = 1'b1;
          end
        end
      end else begin
        case (req_i.spi_byte)
          CmdLampOn: begin
            lamp_d    = 1'b1;
            reply_new = RplAck;
          end
          CmdLampOff: begin
            lamp_d    = 1'b0;
            reply_new = RplAck;
          end
          CmdVentOpen: begin
            servo_d   = {servo_max_q, 1'b0};
            reply_new = RplAck;
          end
          CmdVentClose: begin
            servo_d   = {servo_min_q, 1'b0};
            reply_new = RplAck;
          end
          CmdDoorQuery: begin
            reply_new = {6'b0, snap_new.door};
          end
          CmdStateReq: begin
            snap_load = 1'b1;
            strm_d    = 1'b1;
            pos_d     = '0;
            reply_new = pkt_byte(snap_new, '0);
          end
          CmdLightQry: begin
            reply_new = req_i.light_byte;
          end
          CmdDummy: begin
            reply_new = RplZero;
          end
          default: begin
            reply_new = RplErr;
          end
        endcase
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      servo_min_q <= ServoMinReset;
      servo_max_q <= ServoMaxReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegServoMin: servo_min_q <= cfg_wdata_i;
        RegServoMax: servo_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= '0;
      lamp_q  <= 1'b0;
      servo_q <= {ServoMinReset, 1'b0};
      strm_q  <= 1'b0;
      pos_q   <= '0;
    end else begin
      ts_q    <= ts_d;
      lamp_q  <= lamp_d;
      servo_q <= servo_d;
      strm_q  <= strm_d;
      pos_q   <= pos_d;
    end
  end

  // Fill sweep: write packet bytes one through six after a state request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q  <= 1'b0;
      wr_ptr_q <= '0;
    end else if (snap_load) begin
      sweep_q  <= 1'b1;
      wr_ptr_q <= pos_t'(1);
    end else if (sweep_q) begin
      wr_ptr_q <= wr_ptr_q + pos_t'(1);
      if (wr_ptr_q == PosLast) begin
        sweep_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_load) begin
      snap_q <= snap_new;
    end
  end

  scr_ram #(
    .Width ($bits(byte_t)),
    .Depth (PktLen)
  ) u_pkt_ram (
    .clk_i   (clk_i),
    .we_i    (sweep_q),
    .waddr_i (wr_ptr_q),
    .wdata_i (pkt_byte(snap_q, wr_ptr_q)),
    .re_i    (rd_en),
    .raddr_i (pos_inc),
    .rdata_o (ram_rdata)
  );

  // Output stage: advance when empty or drained, hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= is_spi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_spi) begin
      reply_q     <= reply_new;
      use_ram_q   <= use_ram_new;
      lamp_out_q  <= lamp_d;
      servo_out_q <= servo_d;
    end
  end

  assign rsp_o.valid       = s1_valid_q;
  assign rsp_o.reply_byte  = use_ram_q ? ram_rdata : reply_q;
  assign rsp_o.lamp_on     = lamp_out_q;
  assign rsp_o.servo_ticks = servo_out_q;

endmodule

`default_nettype wire

FILE: sv/scr_checker.sv
`default_nettype none

module scr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        in_req_type_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  out_reply_byte_i,
  input wire logic        out_lamp_on_i,
  input wire logic [15:0] out_servo_ticks_i
);
  import scr_pkg::*;

  logic in_fire, out_free;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_free = !out_valid_i || out_ready_i;

  // Every SPI byte gives a reply in the next cycle.
  a_spi_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_req_type_i == ReqSpi) |=> out_valid_i)
    else $error("SPI byte without reply");

  // A tick taken while the output drains leaves no reply behind.
  a_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_req_type_i == ReqTick) && out_free |=> !out_valid_i)
    else $error("tick produced a reply");

  // A stalled reply holds off the request side.
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("request taken while reply stalled");

  // A stalled reply keeps its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_reply_byte_i)
      && $stable(out_lamp_on_i) && $stable(out_servo_ticks_i))
    else $error("stalled reply changed");

endmodule

bind spi_command_responder scr_checker u_scr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (req_i.valid),
  .in_ready_i        (req_i.ready),
  .in_req_type_i     (req_i.req_type),
  .out_valid_i       (rsp_o.valid),
  .out_ready_i       (rsp_o.ready),
  .out_reply_byte_i  (rsp_o.reply_byte),
  .out_lamp_on_i     (rsp_o.lamp_on),
  .out_servo_ticks_i (rsp_o.servo_ticks)
);

`default_nettype wire
